### hw/rtl/mgid_pkg.sv
// ----------------------------------------------------------------------------
// mgid_pkg: shared types, constants and functions of the marker grid ID decoder
// Holds the 45-entry code table, the grid quarter turn and the per-orientation
// syndrome correction and lookup.
// ----------------------------------------------------------------------------
package mgid_pkg;

  localparam int unsigned CellW  = 9;
  localparam int unsigned IndexW = 6;
  localparam int unsigned TurnsW = 2;
  localparam int unsigned NumRot = 4;

  typedef logic [CellW-1:0]  cells_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [TurnsW-1:0] turns_t;

  // Syndrome codes {s0, s1, s2}
  localparam logic [2:0] SynNone  = 3'b000;
  localparam logic [2:0] SynBit5  = 3'b111;
  localparam logic [2:0] SynBit8  = 3'b110;
  localparam logic [2:0] SynBit4  = 3'b101;
  localparam logic [2:0] SynBit3  = 3'b011;
  localparam logic [2:0] SynBit2  = 3'b001;
  localparam logic [2:0] SynAmbA  = 3'b100;  // try bit 0, then bit 7
  localparam logic [2:0] SynAmbB  = 3'b010;  // try bit 1, then bit 6

  typedef struct packed {
    logic   found;
    index_t marker_id;
    turns_t corner_turns;
  } rsp_t;

  // Reverse bit order so table literals read in cell order (cell 0 leftmost).
  function automatic cells_t rev9(input cells_t c);
    cells_t r;
    for (int k = 0; k < CellW; k++) begin
      r[k] = c[CellW-1-k];
    end
    return r;
  endfunction

  // One-based table position of a code, zero when the code is not valid.
  function automatic index_t code_lookup(input cells_t code);
    index_t idx;
    unique case (rev9(code))
      9'b100000010: idx = 6'd1;
      9'b010000011: idx = 6'd2;
      9'b010000100: idx = 6'd3;
      9'b100000101: idx = 6'd4;
      9'b111001000: idx = 6'd5;
      9'b011001010: idx = 6'd6;
      9'b101001011: idx = 6'd7;
      9'b101001100: idx = 6'd8;
      9'b001001110: idx = 6'd9;
      9'b111001111: idx = 6'd10;
      9'b101010000: idx = 6'd11;
      9'b011010001: idx = 6'd12;
      9'b111010011: idx = 6'd13;
      9'b111010100: idx = 6'd14;
      9'b001010101: idx = 6'd15;
      9'b101010111: idx = 6'd16;
      9'b010011000: idx = 6'd17;
      9'b100011001: idx = 6'd18;
      9'b110011010: idx = 6'd19;
      9'b000011100: idx = 6'd20;
      9'b110011101: idx = 6'd21;
      9'b100011110: idx = 6'd22;
      9'b010011111: idx = 6'd23;
      9'b011100000: idx = 6'd24;
      9'b101100001: idx = 6'd25;
      9'b111100010: idx = 6'd26;
      9'b001100011: idx = 6'd27;
      9'b111100101: idx = 6'd28;
      9'b011100111: idx = 6'd29;
      9'b100101000: idx = 6'd30;
      9'b010101001: idx = 6'd31;
      9'b000101010: idx = 6'd32;
      9'b110101100: idx = 6'd33;
      9'b010101110: idx = 6'd34;
      9'b100101111: idx = 6'd35;
      9'b010110010: idx = 6'd36;
      9'b100110011: idx = 6'd37;
      9'b100110100: idx = 6'd38;
      9'b010110101: idx = 6'd39;
      9'b001111000: idx = 6'd40;
      9'b111111001: idx = 6'd41;
      9'b101111010: idx = 6'd42;
      9'b011111011: idx = 6'd43;
      9'b011111100: idx = 6'd44;
      9'b111111110: idx = 6'd45;
      default:      idx = '0;
    endcase
    return idx;
  endfunction

  // Quarter turn clockwise: new[i][j] = old[2-j][i].
  function automatic cells_t turn_cw(input cells_t c);
    cells_t r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r[i*3+j] = c[(2-j)*3+i];
      end
    end
    return r;
  endfunction

  // Correct at most one bit by syndrome and return the table index.
  function automatic index_t correct_find(input cells_t c);
    logic       s0;
    logic       s1;
    logic       s2;
    index_t     first_idx;
    index_t     idx;
    s0 = c[0] ^ c[4] ^ c[5] ^ c[7] ^ c[8];
    s1 = c[1] ^ c[3] ^ c[5] ^ c[6] ^ c[8];
    s2 = c[2] ^ c[3] ^ c[4] ^ c[5];
    unique case ({s0, s1, s2})
      SynNone: idx = code_lookup(c);
      SynBit5: idx = code_lookup(c ^ 9'h020);
      SynBit8: idx = code_lookup(c ^ 9'h100);
      SynBit4: idx = code_lookup(c ^ 9'h010);
      SynBit3: idx = code_lookup(c ^ 9'h008);
      SynBit2: idx = code_lookup(c ^ 9'h004);
      SynAmbA: begin
        first_idx = code_lookup(c ^ 9'h001);
        idx = (first_idx != '0) ? first_idx : code_lookup(c ^ 9'h080);
      end
      SynAmbB: begin
        first_idx = code_lookup(c ^ 9'h002);
        idx = (first_idx != '0) ? first_idx : code_lookup(c ^ 9'h040);
      end
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

### hw/rtl/mgid_req_if.sv
// ----------------------------------------------------------------------------
// mgid_req_if: request channel of the marker grid ID decoder
// Valid/ready handshake carrying the nine cell bits and the tie mask.
// ----------------------------------------------------------------------------
interface mgid_req_if;
  logic                       valid;
  logic                       ready;
  logic [mgid_pkg::CellW-1:0] cell_bits;
  logic [mgid_pkg::CellW-1:0] cell_tie;

  modport source (output valid, output cell_bits, output cell_tie, input ready);
  modport sink   (input valid, input cell_bits, input cell_tie, output ready);
endinterface

### hw/rtl/mgid_rsp_if.sv
// ----------------------------------------------------------------------------
// mgid_rsp_if: result channel of the marker grid ID decoder
// Valid/ready handshake carrying the decode flag, code index and turns.
// ----------------------------------------------------------------------------
interface mgid_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mgid_pkg::IndexW-1:0] marker_id;
  logic [mgid_pkg::TurnsW-1:0] corner_turns;

  modport source (output valid, output found, output marker_id, output corner_turns,
                  input ready);
  modport sink   (input valid, input found, input marker_id, input corner_turns,
                  output ready);
endinterface

### hw/rtl/marker_grid_id_decoder.sv
// ----------------------------------------------------------------------------
// marker_grid_id_decoder: 3x3 fiducial marker identity decoder
// Decodes a thresholded 3x3 grid in four orientations with single-bit
// syndrome correction and reports the last orientation that hits the table.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                               | handshake
//  --------+-----+--------------------------------------+------------------
//  req_i   | in  | cell_bits[8:0], cell_tie[8:0]        | valid/ready
//  rsp_o   | out | found, marker_id[5:0], corner_turns   | valid/ready
//
//  One request per cycle unless the result is stalled: the request lands in
//  an input register, the four orientation decodes and the merge run in one
//  combinational pass, and the result lands in the output register.
//  Each stage takes new data when it is empty or its contents move on, so a
//  stalled result holds while the input register still fills once.
//  Reset clears both valid flags; payload registers are not reset.
//
module marker_grid_id_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  mgid_req_if.sink   req_i,
  mgid_rsp_if.source rsp_o
);
  import mgid_pkg::*;

  // Input stage
  logic   in_valid_q;
  cells_t cells_q;
  cells_t ties_q;

  // Output stage
  logic   out_valid_q;
  rsp_t   rsp_q;
  rsp_t   rsp_d;

  logic   out_ready;
  logic   in_ready;

  index_t rot_idx [NumRot];
  cells_t rot_cells [NumRot];

  // Output register frees up when empty or when its result is taken.
  assign out_ready   = !out_valid_q || rsp_o.ready;
  // Input register advances whenever the output register can take its result.
  assign in_ready    = !in_valid_q || out_ready;
  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      cells_q <= req_i.cell_bits;
      ties_q  <= req_i.cell_tie;
    end
  end

  // Build the four orientations: 0, 90, 180 and 270 degrees clockwise.
  always_comb begin
    rot_cells[0] = cells_q;
    for (int r = 1; r < NumRot; r++) begin
      rot_cells[r] = turn_cw(rot_cells[r-1]);
    end
    for (int r = 0; r < NumRot; r++) begin
      rot_idx[r] = correct_find(rot_cells[r]);
    end
  end

  // Merge: the latest orientation with a hit wins; any tie kills the match.
  always_comb begin
    rsp_d = '0;
    if (ties_q == '0) begin
      for (int r = 0; r < NumRot; r++) begin
        if (rot_idx[r] != '0) begin
          rsp_d.found        = 1'b1;
          rsp_d.marker_id    = rot_idx[r];
          // Corner reorder turns run one ahead of the orientation, wrapping.
          rsp_d.corner_turns = TurnsW'(r + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = rsp_q.found;
  assign rsp_o.marker_id    = rsp_q.marker_id;
  assign rsp_o.corner_turns = rsp_q.corner_turns;

endmodule

### tb/marker_grid_id_checker.sv
// ----------------------------------------------------------------------------
// marker_grid_id_checker: scoreboard for the marker grid ID decoder
// Watches both channels, predicts the decode of every accepted request from
// its own code table, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module marker_grid_id_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  mgid_pkg::cells_t cell_bits_i,
  input  mgid_pkg::cells_t cell_tie_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  input  logic             found_i,
  input  mgid_pkg::index_t marker_id_i,
  input  mgid_pkg::turns_t corner_turns_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      decodes_o,
  output int unsigned      hits_o
);
  import mgid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rsp_t   want;
    cells_t cells;
  } pending_decode_t;

  // Valid codes, written with cell 0 as the leftmost character.
  localparam cells_t CodeList [45] = '{
    9'b100000010, 9'b010000011, 9'b010000100, 9'b100000101, 9'b111001000,
    9'b011001010, 9'b101001011, 9'b101001100, 9'b001001110, 9'b111001111,
    9'b101010000, 9'b011010001, 9'b111010011, 9'b111010100, 9'b001010101,
    9'b101010111, 9'b010011000, 9'b100011001, 9'b110011010, 9'b000011100,
    9'b110011101, 9'b100011110, 9'b010011111, 9'b011100000, 9'b101100001,
    9'b111100010, 9'b001100011, 9'b111100101, 9'b011100111, 9'b100101000,
    9'b010101001, 9'b000101010, 9'b110101100, 9'b010101110, 9'b100101111,
    9'b010110010, 9'b100110011, 9'b100110100, 9'b010110101, 9'b001111000,
    9'b111111001, 9'b101111010, 9'b011111011, 9'b011111100, 9'b111111110
  };

  index_t          id_of_word [512];
  pending_decode_t expected_decodes [$];
  int unsigned     mismatches;
  int unsigned     outstanding;
  int unsigned     decodes;
  int unsigned     hits;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;
  assign decodes_o    = decodes;
  assign hits_o       = hits;

  initial begin : build_id_table
    cells_t w;
    mismatches  = 0;
    outstanding = 0;
    decodes     = 0;
    hits        = 0;
    for (int a = 0; a < 512; a++) id_of_word[a] = '0;
    for (int n = 0; n < 45; n++) begin
      for (int k = 0; k < CellW; k++) w[k] = CodeList[n][CellW-1-k];
      id_of_word[w] = index_t'(n + 1);
    end
  end

  function automatic cells_t quarter_turn(input cells_t g);
    cells_t r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) r[i*3+j] = g[(2-j)*3+i];
    end
    return r;
  endfunction

  // Single-bit repair by syndrome, then table lookup of the repaired word.
  function automatic index_t fix_and_lookup(input cells_t g);
    logic   s0;
    logic   s1;
    logic   s2;
    cells_t t;
    s0 = g[0] ^ g[4] ^ g[5] ^ g[7] ^ g[8];
    s1 = g[1] ^ g[3] ^ g[5] ^ g[6] ^ g[8];
    s2 = g[2] ^ g[3] ^ g[4] ^ g[5];
    case ({s0, s1, s2})
      SynNone: t = g;
      SynBit5: t = g ^ 9'h020;
      SynBit8: t = g ^ 9'h100;
      SynBit4: t = g ^ 9'h010;
      SynBit3: t = g ^ 9'h008;
      SynBit2: t = g ^ 9'h004;
      SynAmbA: begin
        t = g ^ 9'h001;
        if (id_of_word[t] == '0) t = g ^ 9'h080;
      end
      default: begin
        t = g ^ 9'h002;
        if (id_of_word[t] == '0) t = g ^ 9'h040;
      end
    endcase
    return id_of_word[t];
  endfunction

  function automatic rsp_t predict_decode(input cells_t cells, input cells_t ties);
    rsp_t   r;
    cells_t g;
    index_t hit;
    r = '0;
    g = cells;
    if (ties == '0) begin
      for (int q = 0; q < NumRot; q++) begin
        hit = fix_and_lookup(g);
        if (hit != '0) begin
          r.found        = 1'b1;
          r.marker_id    = hit;
          r.corner_turns = turns_t'(q + 1);
        end
        g = quarter_turn(g);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want, input cells_t cells);
    $display("[%0t] decode mismatch, %s: got %0d, want %0d (grid %03h)",
             $realtime, what, got, want, cells);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : watch
    pending_decode_t e;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        e.want  = predict_decode(cell_bits_i, cell_tie_i);
        e.cells = cell_bits_i;
        expected_decodes.push_back(e);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        decodes++;
        if (found_i) hits++;
        if (expected_decodes.size() == 0) begin
          report_mismatch("result with no request pending", 32'(found_i), 0, '0);
        end else begin
          e = expected_decodes.pop_front();
          if (found_i !== e.want.found)
            report_mismatch("found", 32'(found_i), 32'(e.want.found), e.cells);
          if (marker_id_i !== e.want.marker_id)
            report_mismatch("marker_id", 32'(marker_id_i), 32'(e.want.marker_id),
                            e.cells);
          if (corner_turns_i !== e.want.corner_turns)
            report_mismatch("corner_turns", 32'(corner_turns_i),
                            32'(e.want.corner_turns), e.cells);
        end
      end
      outstanding = expected_decodes.size();
    end
  end

endmodule

### tb/tb_marker_grid_id_decoder.sv
// ----------------------------------------------------------------------------
// tb_marker_grid_id_decoder: testbench of the marker grid ID decoder
// Drives directed and random grids through the request channel under three
// idle profiles and one long result stall; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_marker_grid_id_decoder;
  import mgid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod      = 20;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned RandomGrids    = 2000;
  localparam int unsigned LongHoldCycles = 64;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned NumDirected    = 17;

  // Directed grids: blank, full, all undecided, first and last codes, single
  // undecided cells, each fixed-bit repair, and both tries of each ambiguous
  // syndrome (first flip lands in the table, first flip misses).
  localparam cells_t DirCells [NumDirected] = '{
    9'h000, 9'h1FF, 9'h1FF, 9'h081, 9'h0FF, 9'h182, 9'h081, 9'h081,
    9'h085, 9'h089, 9'h091, 9'h0A1, 9'h181, 9'h080, 9'h001, 9'h180, 9'h1C2
  };
  localparam cells_t DirTies [NumDirected] = '{
    9'h000, 9'h000, 9'h1FF, 9'h000, 9'h000, 9'h000, 9'h100, 9'h001,
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        long_hold_req;
  logic        long_hold_done;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned grids_sent;
  int unsigned tie_grids;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned decodes;
  int unsigned hits;

  mgid_req_if req_if ();
  mgid_rsp_if rsp_if ();

  marker_grid_id_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  marker_grid_id_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .cell_bits_i    (req_if.cell_bits),
    .cell_tie_i     (req_if.cell_tie),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .found_i        (rsp_if.found),
    .marker_id_i    (rsp_if.marker_id),
    .corner_turns_i (rsp_if.corner_turns),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .decodes_o      (decodes),
    .hits_o         (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog: end the run if the handshakes stop making progress.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d decodes still pending", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Build a parity-consistent word from six data bits, so that most random
  // grids reach the table lookup instead of dying in the repair step.
  function automatic cells_t coded_grid(input logic [5:0] data);
    cells_t w;
    w[8:3] = data;
    w[0]   = w[4] ^ w[5] ^ w[7] ^ w[8];
    w[1]   = w[3] ^ w[5] ^ w[6] ^ w[8];
    w[2]   = w[3] ^ w[4] ^ w[5];
    return w;
  endfunction

  // Offer one request and hold it until the decoder takes it. Idle cycles
  // come first, so valid stays high between back-to-back requests.
  task automatic send_grid(input cells_t cells, input cells_t ties);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid     <= 1'b0;
      req_if.cell_bits <= cells_t'($urandom);
      req_if.cell_tie  <= cells_t'($urandom);
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cell_bits <= cells;
    req_if.cell_tie  <= ties;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    grids_sent++;
    if (ties != '0) tie_grids++;
  endtask

  // Result side: random back-pressure, plus one long hold-off once the
  // sender stops idling, so both pipeline stages fill and req ready drops.
  initial begin
    rsp_if.ready   <= 1'b0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && long_hold_req && !long_hold_done) begin
        hold_left      = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    cells_t      cells;
    cells_t      ties;
    int unsigned pick;
    rst_ni           = 1'b0;
    req_if.valid     <= 1'b0;
    req_if.cell_bits <= '0;
    req_if.cell_tie  <= '0;
    send_idle_pct    = 32;
    recv_idle_pct    = 59;
    long_hold_req    = 1'b0;
    grids_sent       = 0;
    tie_grids        = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NumDirected; n++) send_grid(DirCells[n], DirTies[n]);

    for (int n = 0; n < RandomGrids; n++) begin
      // Swap the idle profile a third of the way in, then drop idling and
      // trigger the long result stall for the last third.
      if (n == RandomGrids / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 32;
      end
      if (n == 2 * RandomGrids / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
      end
      pick = $urandom_range(99);
      ties = '0;
      if (pick < 45) begin
        // clean or single-error code word
        cells = coded_grid(6'($urandom));
        if ($urandom_range(3) != 0) cells[$urandom_range(8)] ^= 1'b1;
      end else if (pick < 55) begin
        // two errors: repair may land on a wrong code or miss the table
        cells = coded_grid(6'($urandom));
        cells[$urandom_range(8)] ^= 1'b1;
        cells[$urandom_range(8)] ^= 1'b1;
      end else if (pick < 78) begin
        cells = cells_t'($urandom);
      end else begin
        // undecided cells, alone or scattered, over any grid
        cells = ($urandom_range(1) != 0) ? coded_grid(6'($urandom)) : cells_t'($urandom);
        if ($urandom_range(1) != 0) ties[$urandom_range(8)] = 1'b1;
        else ties = cells_t'($urandom_range(511, 1));
      end
      send_grid(cells, ties);
    end
    req_if.valid <= 1'b0;

    // Let the last push land, wait for every decode, then watch for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d grids (%0d directed, %0d with undecided cells) under three idle",
             grids_sent, NumDirected, tie_grids);
    $display("profiles and a %0d-cycle result stall; %0d decodes checked, %0d found a code.",
             LongHoldCycles, decodes, hits);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
